// ===== hdl/ipv4p_pkg.sv =====
// Shared constants, types and helpers for the dotted-decimal IPv4 parser.
// No dependencies; every other file of the block imports this package.
package ipv4p_pkg;

    localparam int unsigned CharWidth   = 8;
    localparam int unsigned AddrWidth   = 32;
    localparam int unsigned OctetWidth  = 8;
    localparam int unsigned ValueWidth  = 10;
    localparam int unsigned CountWidth  = 2;
    localparam int unsigned ClosedWidth = 3;
    localparam int unsigned OctetCount  = 4;

    localparam logic [CharWidth-1:0]  CharNul   = 8'h00;
    localparam logic [CharWidth-1:0]  CharDot   = 8'h2E;
    localparam logic [CharWidth-1:0]  CharZero  = 8'h30;
    localparam logic [CharWidth-1:0]  CharNine  = 8'h39;
    localparam logic [CountWidth-1:0] DigitsKept = 2'd3;
    localparam logic [ValueWidth-1:0] OctetMax  = 10'd255;

    // Handshake pair between two internal stages.
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hand;

    // Saturate a decimal value of up to three digits to one octet.
    function automatic logic [OctetWidth-1:0] sat_octet(input logic [ValueWidth-1:0] v);
        logic [OctetWidth-1:0] res;
        if (v > OctetMax) begin
            res = OctetMax[OctetWidth-1:0];
        end else begin
            res = v[OctetWidth-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/ipv4p_in_stage.sv =====
// Input register of the parser: holds one character beat until the core takes it.
// Depends on ipv4p_pkg.
module ipv4p_in_stage import ipv4p_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CharWidth-1:0] i_character,
    input  logic                 i_take,
    output logic                 o_held_valid,
    output logic [CharWidth-1:0] o_held_char
);

    logic                 r_valid;
    logic                 n_valid;
    logic [CharWidth-1:0] r_char;
    logic                 load;

    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;
    assign n_valid = load || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_character;
        end
    end

    assign o_held_valid = r_valid;
    assign o_held_char  = r_char;

endmodule

// ===== hdl/ipv4p_core.sv =====
// Parse state and per-character update: digit accumulation, octet close, stop on any
// other character and address assembly on the terminating NUL. Depends on ipv4p_pkg.
module ipv4p_core import ipv4p_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_hand                i_in,
    input  logic [CharWidth-1:0] i_char,
    input  logic                 i_out_space,
    output logic                 o_take,
    output logic                 o_res_valid,
    output logic [AddrWidth-1:0] o_res_address
);

    logic [CountWidth-1:0]  r_digit_count;
    logic [CountWidth-1:0]  n_digit_count;
    logic [ValueWidth-1:0]  r_octet_value;
    logic [ValueWidth-1:0]  n_octet_value;
    logic [ClosedWidth-1:0] r_octets_closed;
    logic [ClosedWidth-1:0] n_octets_closed;
    logic [OctetWidth-1:0]  r_store [OctetCount];
    logic [OctetWidth-1:0]  n_store [OctetCount];
    logic                   r_stopped;
    logic                   n_stopped;

    logic                   is_nul;
    logic                   is_dot;
    logic                   is_digit;
    logic                   fire;
    logic                   has_room;
    logic                   pending;
    logic [OctetWidth-1:0]  sat_value;
    logic [OctetWidth-1:0]  close_value;
    logic [ValueWidth-1:0]  base_value;
    logic [ValueWidth+3:0]  times_ten;
    logic [CharWidth-1:0]   digit;
    logic [OctetWidth-1:0]  octet [OctetCount];

    assign is_nul   = (i_char == CharNul);
    assign is_dot   = (i_char == CharDot);
    assign is_digit = (i_char inside {[CharZero:CharNine]});

    // A NUL can only go once the output register has room for the address.
    assign fire     = i_in.valid && (!is_nul || i_out_space);
    assign o_take   = fire;
    assign has_room = !r_octets_closed[ClosedWidth-1];
    assign pending  = has_room && (r_digit_count != '0);

    assign sat_value   = sat_octet(r_octet_value);
    assign close_value = (r_digit_count != '0) ? sat_value : '0;
    assign base_value  = (r_digit_count == '0) ? '0 : r_octet_value;
    assign times_ten   = {base_value, 3'b000} + {2'b00, base_value, 1'b0};
    assign digit       = i_char - CharZero;

    always_comb begin
        for (int i = 0; i < OctetCount; i++) begin
            if (pending && (r_octets_closed[1:0] == 2'(i))) begin
                octet[i] = sat_value;
            end else begin
                octet[i] = r_store[i];
            end
        end
    end

    assign o_res_valid   = fire && is_nul;
    assign o_res_address = {octet[0], octet[1], octet[2], octet[3]};

    always_comb begin
        n_digit_count   = r_digit_count;
        n_octet_value   = r_octet_value;
        n_octets_closed = r_octets_closed;
        n_stopped       = r_stopped;
        for (int i = 0; i < OctetCount; i++) begin
            n_store[i] = r_store[i];
        end
        if (is_nul) begin
            n_digit_count   = '0;
            n_octet_value   = '0;
            n_octets_closed = '0;
            n_stopped       = 1'b0;
            for (int i = 0; i < OctetCount; i++) begin
                n_store[i] = '0;
            end
        end else if (!r_stopped) begin
            if (is_dot) begin
                // Dots after the fourth change nothing.
                if (has_room) begin
                    n_store[r_octets_closed[1:0]] = close_value;
                    n_octets_closed = r_octets_closed + 1'b1;
                    n_digit_count   = '0;
                    n_octet_value   = '0;
                end
            end else if (is_digit) begin
                if (r_digit_count < DigitsKept) begin
                    n_octet_value = times_ten[ValueWidth-1:0] + {2'b00, digit};
                    n_digit_count = r_digit_count + 1'b1;
                end
            end else begin
                n_stopped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count   <= '0;
            r_octet_value   <= '0;
            r_octets_closed <= '0;
            r_stopped       <= 1'b0;
            for (int i = 0; i < OctetCount; i++) begin
                r_store[i] <= '0;
            end
        end else if (fire) begin
            r_digit_count   <= n_digit_count;
            r_octet_value   <= n_octet_value;
            r_octets_closed <= n_octets_closed;
            r_stopped       <= n_stopped;
            for (int i = 0; i < OctetCount; i++) begin
                r_store[i] <= n_store[i];
            end
        end
    end

endmodule

// ===== hdl/ipv4p_out_stage.sv =====
// Output register of the parser: holds one address beat until it is taken.
// Depends on ipv4p_pkg.
module ipv4p_out_stage import ipv4p_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [AddrWidth-1:0] i_address,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [AddrWidth-1:0] o_address
);

    logic                 r_valid;
    logic                 n_valid;
    logic [AddrWidth-1:0] r_address;

    assign o_space = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_address <= i_address;
        end
    end

    assign o_valid   = r_valid;
    assign o_address = r_address;

endmodule

// ===== hdl/ipv4_dotted_decimal_parser.sv =====
// Top level of the dotted-decimal IPv4 parser: input register, parse core,
// output register. Depends on ipv4p_pkg, ipv4p_in_stage, ipv4p_core, ipv4p_out_stage.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+---------------------------
//   input    | i_valid / o_ready  | i_character  (8 bits)
//   output   | o_valid / i_ready  | o_address    (32 bits)
//
// One character beat is taken per cycle unless a waiting NUL stalls the input;
// the parse state updates between the input register and the output register.
// A NUL beat goes from the input register to the output register as an address.
// Only a NUL that meets a full, stalled output register waits in the input
// register; other characters keep flowing while an address waits.
// Reset (synchronous, active low) clears all parse state and both valid flags.
module ipv4_dotted_decimal_parser import ipv4p_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CharWidth-1:0] i_character,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [AddrWidth-1:0] o_address
);

    t_hand                in_hand;
    logic [CharWidth-1:0] held_char;
    logic                 take;
    logic                 out_space;
    logic                 res_valid;
    logic [AddrWidth-1:0] res_address;

    assign in_hand.ready = take;

    ipv4p_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_character  (i_character),
        .i_take       (take),
        .o_held_valid (in_hand.valid),
        .o_held_char  (held_char)
    );

    ipv4p_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_hand),
        .i_char        (held_char),
        .i_out_space   (out_space),
        .o_take        (take),
        .o_res_valid   (res_valid),
        .o_res_address (res_address)
    );

    ipv4p_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (res_valid),
        .i_address (res_address),
        .o_space   (out_space),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_address (o_address)
    );

endmodule

// ===== hdl/ipv4p_checker.sv =====
// Port-level checks for the dotted-decimal IPv4 parser, bound to the top level.
// Depends on ipv4p_pkg and ipv4_dotted_decimal_parser.
module ipv4p_checker import ipv4p_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [CharWidth-1:0] i_character,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [AddrWidth-1:0] o_address
);

    // A stalled address beat holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_address))
        else $error("address changed while stalled");

    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A new address only follows a NUL beat taken at the input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && (i_character == CharNul), 2))
        else $error("address without a terminating NUL");

    // With the output register empty nothing can hold the input back.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output is empty");

endmodule

bind ipv4_dotted_decimal_parser ipv4p_checker u_ipv4p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_character (i_character),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_address   (o_address)
);
